// ===== hdl/xdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// xdsc_pkg
// Shared constants, configuration codes and generator functions for the
// xorshift draw-set checker.
// ----------------------------------------------------------------------------
package xdsc_pkg;

  // Default generics.
  localparam int POOL_SIZE_DEF  = 80;
  localparam int PICK_COUNT_DEF = 20;

  // Fixed field widths.
  localparam int STATE_W     = 32;
  localparam int SHIFT_W     = 5;
  localparam int DIR_W       = 3;
  localparam int LOW_W       = 64;
  localparam int HIGH_W      = 16;
  localparam int MASK_W      = LOW_W + HIGH_W;
  localparam int MASK_IDX_W  = $clog2(MASK_W);
  localparam int DEPTH_W     = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT_ONE    = 3'd0,
    CFG_SHIFT_TWO    = 3'd1,
    CFG_SHIFT_THREE  = 3'd2,
    CFG_DIRECTION    = 3'd3,
    CFG_ALLOWED_LOW  = 3'd4,
    CFG_ALLOWED_HIGH = 3'd5
  } cfg_reg_t;

  // Generator settings handed from the register bank to the picker.
  typedef struct packed {
    logic [SHIFT_W-1:0] shift_one;
    logic [SHIFT_W-1:0] shift_two;
    logic [SHIFT_W-1:0] shift_three;
    logic [DIR_W-1:0]   direction;
  } gen_cfg_t;

  // One xorshift stage: x xor (x shifted left or right).
  function automatic logic [STATE_W-1:0] xs_stage(input logic [STATE_W-1:0] x,
                                                  input logic [SHIFT_W-1:0] amount,
                                                  input logic left);
    logic [STATE_W-1:0] shifted;
    shifted = left ? (x << amount) : (x >> amount);
    return x ^ shifted;
  endfunction

  // Full generator step through the three stages.
  function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] x,
                                                 input gen_cfg_t cfg);
    logic [STATE_W-1:0] a;
    logic [STATE_W-1:0] b;
    a = xs_stage(x, cfg.shift_one, cfg.direction[0]);
    b = xs_stage(a, cfg.shift_two, cfg.direction[1]);
    return xs_stage(b, cfg.shift_three, cfg.direction[2]);
  endfunction

endpackage

// ===== hdl/xdsc_picker.sv =====
// ----------------------------------------------------------------------------
// xdsc_picker
// Steps the generator once per pick and turns each word into a swap index
// by a multiply-high against the remaining pool size.
// ----------------------------------------------------------------------------
module xdsc_picker
  import xdsc_pkg::*;
#(
  parameter int POOL_SIZE  = POOL_SIZE_DEF,
  parameter int PICK_COUNT = PICK_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gen_cfg_t                     cfg,
  input  logic                         start,
  input  logic [STATE_W-1:0]           seed,
  input  logic                         kill,
  output logic                         issue_vld,
  output logic [$clog2(POOL_SIZE)-1:0] issue_k,
  output logic [$clog2(POOL_SIZE)-1:0] issue_j
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int VAL_W = $clog2(POOL_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_PICK = IDX_W'(PICK_COUNT - 1);
  localparam logic [VAL_W:0]   LAST_POS  = (VAL_W + 1)'(POOL_SIZE - 1);
  localparam logic [VAL_W-1:0] POOL_VAL  = VAL_W'(POOL_SIZE);

  logic [STATE_W-1:0]       x_r;
  logic [IDX_W-1:0]         k_r;
  logic                     vld_r;
  logic [VAL_W-1:0]         span;
  logic [STATE_W+VAL_W-1:0] prod;
  logic [VAL_W-1:0]         hi;
  logic [VAL_W:0]           jsum;
  logic [VAL_W:0]           jclamp;

  // x_r already holds the stepped word for pick k_r.
  always_comb begin
    span   = POOL_VAL - VAL_W'(k_r);
    prod   = {{VAL_W{1'b0}}, x_r} * {{STATE_W{1'b0}}, span};
    hi     = prod[STATE_W +: VAL_W];
    jsum   = (VAL_W + 1)'(k_r) + (VAL_W + 1)'(hi);
    jclamp = (jsum > LAST_POS) ? LAST_POS : jsum;
  end

  assign issue_vld = vld_r;
  assign issue_k   = k_r;
  assign issue_j   = IDX_W'(jclamp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= '0;
    end else if (start) begin
      x_r   <= xs_step(seed, cfg);
      k_r   <= '0;
      vld_r <= 1'b1;
    end else if (kill) begin
      vld_r <= 1'b0;
    end else if (vld_r) begin
      x_r <= xs_step(x_r, cfg);
      k_r <= k_r + IDX_W'(1);
      if (k_r == LAST_PICK) begin
        vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/xdsc_perm_store.sv =====
// ----------------------------------------------------------------------------
// xdsc_perm_store
// Scratch permutation memory: two registered reads, one write, per-entry
// valid bits that make unwritten entries read as the identity, and
// forwarding of the previous cycle's write.
// ----------------------------------------------------------------------------
module xdsc_perm_store
  import xdsc_pkg::*;
#(
  parameter int POOL_SIZE = POOL_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             rd_en,
  input  logic [$clog2(POOL_SIZE)-1:0]     rd_k,
  input  logic [$clog2(POOL_SIZE)-1:0]     rd_j,
  output logic                             rsp_vld,
  output logic [$clog2(POOL_SIZE)-1:0]     rsp_k,
  output logic [$clog2(POOL_SIZE)-1:0]     rsp_j,
  output logic [$clog2(POOL_SIZE+1)-1:0]   perm_k,
  output logic [$clog2(POOL_SIZE+1)-1:0]   perm_j,
  input  logic                             wr_en,
  input  logic [$clog2(POOL_SIZE)-1:0]     wr_addr,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   wr_data
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int VAL_W = $clog2(POOL_SIZE + 1);

  logic [VAL_W-1:0]     mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] valid_r;
  logic [VAL_W-1:0]     q_k_r;
  logic [VAL_W-1:0]     q_j_r;
  logic                 qv_k_r;
  logic                 qv_j_r;
  logic [IDX_W-1:0]     a_k_r;
  logic [IDX_W-1:0]     a_j_r;
  logic                 rsp_vld_r;
  logic                 lw_v_r;
  logic [IDX_W-1:0]     lw_a_r;
  logic [VAL_W-1:0]     lw_d_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_k_r <= mem[rd_k];
      q_j_r <= mem[rd_j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rsp_vld_r <= 1'b0;
      lw_v_r    <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rsp_vld_r <= rd_en;
      lw_v_r    <= wr_en && !clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_k_r  <= rd_k;
      a_j_r  <= rd_j;
      qv_k_r <= valid_r[rd_k];
      qv_j_r <= valid_r[rd_j];
    end
    if (wr_en) begin
      lw_a_r <= wr_addr;
      lw_d_r <= wr_data;
    end
  end

  // The write issued in the same cycle as the read is not in the read data.
  always_comb begin
    if (lw_v_r && lw_a_r == a_k_r) begin
      perm_k = lw_d_r;
    end else if (qv_k_r) begin
      perm_k = q_k_r;
    end else begin
      perm_k = VAL_W'(a_k_r) + VAL_W'(1);
    end
    if (lw_v_r && lw_a_r == a_j_r) begin
      perm_j = lw_d_r;
    end else if (qv_j_r) begin
      perm_j = q_j_r;
    end else begin
      perm_j = VAL_W'(a_j_r) + VAL_W'(1);
    end
  end

  assign rsp_vld = rsp_vld_r;
  assign rsp_k   = a_k_r;
  assign rsp_j   = a_j_r;

endmodule

// ===== hdl/xorshift_draw_set_checker_unit.sv =====
// ----------------------------------------------------------------------------
// xorshift_draw_set_checker_unit
// Tests one candidate xorshift state per request: draws up to PICK_COUNT
// numbers by a partial Fisher-Yates shuffle and checks each against an
// allowed-set mask, reporting survival or the depth of the first rejection.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   -------   -----------------   -------------------------------------------
//   in        in_valid/in_ready   in_candidate_state
//   out       out_valid/out_ready out_tested_state, out_survived,
//                                 out_reject_depth
//   cfg       cfg_we              cfg_index, cfg_wdata (write only)
//
// Picks: one pick retires per cycle, paced by the loop generator step ->
// multiply-high -> permutation read -> allowed check -> permutation write.
// Reset: synchronous, active low; clears control state, the permutation
// valid bits and loads the register defaults. No clearing pass is needed.
// Stalls: a new request is taken once the previous result has left the
// internal result slot; it may be taken while the result waits on out_ready.
// ----------------------------------------------------------------------------
module xorshift_draw_set_checker_unit
  import xdsc_pkg::*;
#(
  parameter int POOL_SIZE  = POOL_SIZE_DEF,
  parameter int PICK_COUNT = PICK_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [STATE_W-1:0]    in_candidate_state,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATE_W-1:0]    out_tested_state,
  output logic                  out_survived,
  output logic [DEPTH_W-1:0]    out_reject_depth,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int VAL_W = $clog2(POOL_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_PICK = IDX_W'(PICK_COUNT - 1);

  // Configuration registers.
  logic [SHIFT_W-1:0] shift_one_r;
  logic [SHIFT_W-1:0] shift_two_r;
  logic [SHIFT_W-1:0] shift_three_r;
  logic [DIR_W-1:0]   direction_r;
  logic [LOW_W-1:0]   allowed_low_r;
  logic [HIGH_W-1:0]  allowed_high_r;
  gen_cfg_t           gen_cfg;

  // Control and result registers.
  logic               busy_r;
  logic               pend_r;
  logic               pend_surv_r;
  logic [DEPTH_W-1:0] pend_depth_r;
  logic [STATE_W-1:0] tested_r;
  logic               out_valid_r;
  logic [STATE_W-1:0] out_state_r;
  logic               out_surv_r;
  logic [DEPTH_W-1:0] out_depth_r;

  // Datapath between the picker, the store and the check stage.
  logic               accept;
  logic               issue_vld;
  logic [IDX_W-1:0]   issue_k;
  logic [IDX_W-1:0]   issue_j;
  logic               issue_go;
  logic               rsp_vld;
  logic [IDX_W-1:0]   rsp_k;
  logic [IDX_W-1:0]   rsp_j;
  logic [VAL_W-1:0]   perm_k;
  logic [VAL_W-1:0]   perm_j;
  logic [MASK_W-1:0]  allowed_mask;
  logic [VAL_W-1:0]   bit_pos;
  logic               pick_ok;
  logic               reject;
  logic               pass_all;
  logic               done;
  logic               out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy_r && !pend_r;

  // Register bank. Writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_one_r    <= SHIFT_W'(13);
      shift_two_r    <= SHIFT_W'(17);
      shift_three_r  <= SHIFT_W'(5);
      direction_r    <= DIR_W'(5);
      allowed_low_r  <= '0;
      allowed_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHIFT_ONE:    shift_one_r    <= cfg_wdata[SHIFT_W-1:0];
        CFG_SHIFT_TWO:    shift_two_r    <= cfg_wdata[SHIFT_W-1:0];
        CFG_SHIFT_THREE:  shift_three_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_DIRECTION:    direction_r    <= cfg_wdata[DIR_W-1:0];
        CFG_ALLOWED_LOW:  allowed_low_r  <= cfg_wdata[LOW_W-1:0];
        CFG_ALLOWED_HIGH: allowed_high_r <= cfg_wdata[HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign gen_cfg = '{shift_one:   shift_one_r,
                     shift_two:   shift_two_r,
                     shift_three: shift_three_r,
                     direction:   direction_r};

  // The picker runs one pick ahead of the check stage. A rejection kills
  // the pick being issued in the same cycle so it never reaches the store.
  xdsc_picker #(
    .POOL_SIZE  (POOL_SIZE),
    .PICK_COUNT (PICK_COUNT)
  ) u_picker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (gen_cfg),
    .start     (accept),
    .seed      (in_candidate_state),
    .kill      (reject),
    .issue_vld (issue_vld),
    .issue_k   (issue_k),
    .issue_j   (issue_j)
  );

  assign issue_go = issue_vld && !reject;

  // Only the swap target needs writing back: position k is never read
  // again by a later pick, and the drawn number is the old entry at j.
  xdsc_perm_store #(
    .POOL_SIZE (POOL_SIZE)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (accept),
    .rd_en   (issue_go),
    .rd_k    (issue_k),
    .rd_j    (issue_j),
    .rsp_vld (rsp_vld),
    .rsp_k   (rsp_k),
    .rsp_j   (rsp_j),
    .perm_k  (perm_k),
    .perm_j  (perm_j),
    .wr_en   (rsp_vld),
    .wr_addr (rsp_j),
    .wr_data (perm_k)
  );

  // Check stage: number n is allowed when mask bit n-1 is set.
  assign allowed_mask = {allowed_high_r, allowed_low_r};
  assign bit_pos      = perm_j - VAL_W'(1);
  assign pick_ok      = allowed_mask[MASK_IDX_W'(bit_pos)];
  assign reject       = rsp_vld && !pick_ok;
  assign pass_all     = rsp_vld && pick_ok && (rsp_k == LAST_PICK);
  assign done         = reject || pass_all;
  assign out_free     = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (done) begin
        pend_r <= 1'b1;
      end else if (pend_r && out_free) begin
        pend_r <= 1'b0;
      end
      if (pend_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tested_r <= in_candidate_state;
    end
    if (done) begin
      pend_surv_r  <= pass_all;
      pend_depth_r <= pass_all ? '0 : DEPTH_W'(rsp_k);
    end
    if (pend_r && out_free) begin
      out_state_r <= tested_r;
      out_surv_r  <= pend_surv_r;
      out_depth_r <= pend_depth_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tested_state = out_state_r;
  assign out_survived     = out_surv_r;
  assign out_reject_depth = out_depth_r;

  // A finished result and a request in progress never coexist.
  a_busy_pend: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pend_r)
    else $error("result pending while a request is still in progress");

  // The permutation is written only on behalf of a request in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld |-> busy_r)
    else $error("permutation write outside a request");

  // An accepted request starts the pick loop.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && issue_vld))
    else $error("accepted request did not start");

  // Every finished request lands in the result slot.
  a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> pend_r)
    else $error("finished request lost");

  // A surviving state reports depth zero.
  a_surv_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_surv_r) |-> (out_depth_r == '0))
    else $error("survivor with nonzero reject depth");

endmodule
